### rtl/bsd_pkg.sv
// Package: shared types and constants of the backslash escape decoder.
`default_nettype none
package bsd_pkg;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_ESC   = 2'd1;
   localparam logic [1:0] MODE_OCT   = 2'd2;

   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_OCT_LO = 8'h30;  // '0'
   localparam logic [7:0] CHR_OCT_HI = 8'h37;  // '7'
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_T      = 8'h74;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_B      = 8'h62;
   localparam logic [7:0] CHR_F      = 8'h66;

   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;

   localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

   // result queue
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTRW  = 2;
   localparam int unsigned QCNTW  = 3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] accum;
      logic [1:0] digits;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
      logic       run_last;
   } result_type;

   typedef struct packed {
      state_type  nxt;
      logic [1:0] num;
      result_type res0;
      result_type res1;
   } decode_type;

endpackage
`default_nettype wire

### rtl/bsd_decode.sv
// Combinational decode of one item against the current escape state.
`default_nettype none
module bsd_decode (
   input  wire logic              [7:0] in_byte,
   input  wire logic                    end_flag,
   input  wire bsd_pkg::state_type      cur,
   output bsd_pkg::decode_type          dec
);

   logic [7:0] acc_shift;
   logic [1:0] dig_inc;

   assign acc_shift = {cur.accum[4:0], in_byte[2:0]};
   assign dig_inc   = cur.digits + 2'd1;

   always_comb begin
      dec      = '0;
      dec.nxt  = cur;
      if (end_flag) begin
         if (cur.mode == bsd_pkg::MODE_ESC) begin
            dec.res0 = '{out_byte: bsd_pkg::CHR_BSLASH, end_marker: 1'b0, run_last: 1'b0};
            dec.res1 = '{out_byte: 8'h00, end_marker: 1'b1, run_last: 1'b1};
            dec.num  = 2'd2;
         end else if (cur.mode == bsd_pkg::MODE_OCT) begin
            dec.res0 = '{out_byte: cur.accum, end_marker: 1'b0, run_last: 1'b0};
            dec.res1 = '{out_byte: 8'h00, end_marker: 1'b1, run_last: 1'b1};
            dec.num  = 2'd2;
         end else begin
            dec.res0 = '{out_byte: 8'h00, end_marker: 1'b1, run_last: 1'b1};
            dec.num  = 2'd1;
         end
         dec.nxt = '{mode: bsd_pkg::MODE_PLAIN, accum: 8'h00, digits: 2'd0};
      end else begin
         case (cur.mode)
            bsd_pkg::MODE_ESC: begin
               dec.nxt.mode = bsd_pkg::MODE_PLAIN;
               dec.num      = 2'd1;
               dec.res0     = '{out_byte: in_byte, end_marker: 1'b0, run_last: 1'b1};
               case (in_byte)
                  bsd_pkg::CHR_N: dec.res0.out_byte = bsd_pkg::CTL_LF;
                  bsd_pkg::CHR_T: dec.res0.out_byte = bsd_pkg::CTL_HT;
                  bsd_pkg::CHR_R: dec.res0.out_byte = bsd_pkg::CTL_CR;
                  bsd_pkg::CHR_B: dec.res0.out_byte = bsd_pkg::CTL_BS;
                  bsd_pkg::CHR_F: dec.res0.out_byte = bsd_pkg::CTL_FF;
                  default: begin
                     if (in_byte inside {[bsd_pkg::CHR_OCT_LO:bsd_pkg::CHR_OCT_HI]}) begin
                        dec.nxt = '{mode: bsd_pkg::MODE_OCT,
                                    accum: {5'd0, in_byte[2:0]}, digits: 2'd1};
                        dec.num = 2'd0;
                     end
                  end
               endcase
            end
            bsd_pkg::MODE_OCT: begin
               if (in_byte inside {[bsd_pkg::CHR_OCT_LO:bsd_pkg::CHR_OCT_HI]}) begin
                  dec.nxt.accum  = acc_shift;
                  dec.nxt.digits = dig_inc;
                  if (dig_inc == bsd_pkg::OCT_MAX_DIGITS) begin
                     dec.res0 = '{out_byte: acc_shift, end_marker: 1'b0, run_last: 1'b1};
                     dec.num  = 2'd1;
                     dec.nxt  = '{mode: bsd_pkg::MODE_PLAIN, accum: 8'h00, digits: 2'd0};
                  end
               end else begin
                  // flush the pending value, then treat the byte as plain
                  dec.nxt = '{mode: bsd_pkg::MODE_PLAIN, accum: 8'h00, digits: 2'd0};
                  if (in_byte == bsd_pkg::CHR_BSLASH) begin
                     dec.nxt.mode = bsd_pkg::MODE_ESC;
                     dec.res0 = '{out_byte: cur.accum, end_marker: 1'b0, run_last: 1'b1};
                     dec.num  = 2'd1;
                  end else begin
                     dec.res0 = '{out_byte: cur.accum, end_marker: 1'b0, run_last: 1'b0};
                     dec.res1 = '{out_byte: in_byte, end_marker: 1'b0, run_last: 1'b1};
                     dec.num  = 2'd2;
                  end
               end
            end
            default: begin
               // plain mode; the unused code behaves the same
               if (in_byte == bsd_pkg::CHR_BSLASH) begin
                  dec.nxt.mode = bsd_pkg::MODE_ESC;
               end else begin
                  dec.nxt.mode = bsd_pkg::MODE_PLAIN;
                  dec.res0 = '{out_byte: in_byte, end_marker: 1'b0, run_last: 1'b1};
                  dec.num  = 2'd1;
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/backslash_escape_decoder_top.sv
// Top level: backslash escape decoder with a small result queue.
//
// Usage:
//   req channel: one text byte per item (req_in_byte), or an end-of-string
//   item (req_end_flag = 1) that closes the current string.
//   rsp channel: decoded bytes; an end item gives an end marker, preceded by
//   a dangling backslash or pending octal value if there is one.
//   rsp_run_last marks the last result that an input item caused.
// Path: each result is registered in the result queue and reaches rsp after the results ahead of it.
// Throughput: one item per cycle while rsp_ready is high and each item gives
//   at most one result. The rsp side moves one result per cycle, so items
//   that give two results (octal flush, end of string after an escape) fill
//   the four-entry queue; req_ready drops while it holds more than two entries.
// Stall: while rsp_ready is low results wait in the queue, in order; the
//   input side keeps accepting until the queue lacks room for two results.
// Reset: synchronous, active high; empties the queue and returns the
//   decoder to plain mode with a cleared octal value.
`default_nettype none
module backslash_escape_decoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_flag,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_end_marker,
   output logic            rsp_run_last
);

   bsd_pkg::state_type  state_ff, state_in;
   bsd_pkg::decode_type dec;
   bsd_pkg::result_type q_ff [bsd_pkg::QDEPTH];

   logic [bsd_pkg::QPTRW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_p1;
   logic [bsd_pkg::QCNTW-1:0] count_ff, count_in;
   logic                      accept, pop;

   bsd_decode u_decode (
      .in_byte  (req_in_byte),
      .end_flag (req_end_flag),
      .cur      (state_ff),
      .dec      (dec)
   );

   assign req_ready = (count_ff <= bsd_pkg::QCNTW'(bsd_pkg::QDEPTH - 2));
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;
   assign wr_ptr_p1 = wr_ptr_ff + 1'b1;

   assign rsp_out_byte   = q_ff[rd_ptr_ff].out_byte;
   assign rsp_end_marker = q_ff[rd_ptr_ff].end_marker;
   assign rsp_run_last   = q_ff[rd_ptr_ff].run_last;

   always_comb begin
      state_in  = accept ? dec.nxt : state_ff;
      wr_ptr_in = accept ? wr_ptr_ff + dec.num : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (accept ? {1'b0, dec.num} : '0)
                  - {{(bsd_pkg::QCNTW-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '{mode: bsd_pkg::MODE_PLAIN, accum: 8'h00, digits: 2'd0};
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && dec.num != 2'd0) begin
         q_ff[wr_ptr_ff] <= dec.res0;
      end
      if (accept && dec.num == 2'd2) begin
         q_ff[wr_ptr_p1] <= dec.res1;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bsd_pkg::QCNTW'(bsd_pkg::QDEPTH))
      else $error("result queue overfilled");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_flag |-> dec.num != 2'd0 && (dec.num == 2'd1 ?
         dec.res0.end_marker : dec.res1.end_marker))
      else $error("end item without end marker");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_flag |=> state_ff.mode == bsd_pkg::MODE_PLAIN &&
         state_ff.accum == 8'h00 && state_ff.digits == 2'd0)
      else $error("state not cleared after end of string");

   a_oct_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == bsd_pkg::MODE_OCT |->
         state_ff.digits == 2'd1 || state_ff.digits == 2'd2)
      else $error("octal digit count out of range");
`endif

endmodule
`default_nettype wire

### tb/backslash_escape_decoder_top_test.sv
// Testbench for the backslash escape decoder: directed table, random text, self-checking.
`timescale 1ns / 1ps
module backslash_escape_decoder_top_test;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 30;
   localparam int USE_MODEL    = -1;

   localparam bsd_pkg::result_type NO_RES   = '0;
   localparam bsd_pkg::result_type END_ONLY = {8'h00, 1'b1, 1'b1};

   typedef struct {
      logic [7:0]          ch;
      logic                endf;
      int                  nexp;    // typed result count, or USE_MODEL
      bsd_pkg::result_type r0;
      bsd_pkg::result_type r1;
   } text_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_flag = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_marker;
   logic       rsp_run_last;

   text_item_type       text_q[$];
   bsd_pkg::result_type decoded_q[$];

   // decoder state as seen by the predictor
   logic [1:0] dec_mode = bsd_pkg::MODE_PLAIN;
   logic [7:0] oct_val = 8'h00;
   logic [1:0] oct_cnt = 2'd0;

   int n_errors  = 0;
   int n_taken   = 0;
   int n_results = 0;
   int n_strings = 0;
   int n_pairs   = 0;
   int n_blocked = 0;
   int cycles    = 0;

   backslash_escape_decoder_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_end_flag   (req_end_flag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker),
      .rsp_run_last   (rsp_run_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic note_mismatch(input string msg);
      if (n_errors < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic add_text(input logic [7:0] ch, input logic endf, input int nexp,
                           input bsd_pkg::result_type r0, input bsd_pkg::result_type r1);
      text_item_type it;
      it.ch   = ch;
      it.endf = endf;
      it.nexp = nexp;
      it.r0   = r0;
      it.r1   = r1;
      text_q.push_back(it);
   endtask

   // Decodes one item, updates the predictor state, returns the result count.
   function automatic int decode_step(input logic [7:0] c, input logic endf,
                                      output bsd_pkg::result_type r0,
                                      output bsd_pkg::result_type r1);
      bsd_pkg::result_type rr[2];
      int                  n;
      logic                take_plain;
      n = 0;
      rr[0] = NO_RES;
      rr[1] = NO_RES;
      take_plain = 1'b0;
      if (endf) begin
         if (dec_mode == bsd_pkg::MODE_ESC) begin
            rr[n] = {bsd_pkg::CHR_BSLASH, 1'b0, 1'b0};
            n = n + 1;
         end else if (dec_mode == bsd_pkg::MODE_OCT) begin
            rr[n] = {oct_val, 1'b0, 1'b0};
            n = n + 1;
         end
         rr[n] = {8'h00, 1'b1, 1'b0};
         n = n + 1;
         dec_mode = bsd_pkg::MODE_PLAIN;
         oct_val  = 8'h00;
         oct_cnt  = 2'd0;
      end else if (dec_mode == bsd_pkg::MODE_ESC) begin
         dec_mode = bsd_pkg::MODE_PLAIN;
         case (c)
            bsd_pkg::CHR_N: begin rr[n] = {bsd_pkg::CTL_LF, 2'b00}; n = n + 1; end
            bsd_pkg::CHR_T: begin rr[n] = {bsd_pkg::CTL_HT, 2'b00}; n = n + 1; end
            bsd_pkg::CHR_R: begin rr[n] = {bsd_pkg::CTL_CR, 2'b00}; n = n + 1; end
            bsd_pkg::CHR_B: begin rr[n] = {bsd_pkg::CTL_BS, 2'b00}; n = n + 1; end
            bsd_pkg::CHR_F: begin rr[n] = {bsd_pkg::CTL_FF, 2'b00}; n = n + 1; end
            default: begin
               if (c >= bsd_pkg::CHR_OCT_LO && c <= bsd_pkg::CHR_OCT_HI) begin
                  dec_mode = bsd_pkg::MODE_OCT;
                  oct_val  = c - bsd_pkg::CHR_OCT_LO;
                  oct_cnt  = 2'd1;
               end else begin
                  rr[n] = {c, 2'b00};
                  n = n + 1;
               end
            end
         endcase
      end else if (dec_mode == bsd_pkg::MODE_OCT) begin
         if (c >= bsd_pkg::CHR_OCT_LO && c <= bsd_pkg::CHR_OCT_HI) begin
            oct_val = {oct_val[4:0], 3'b000} + (c - bsd_pkg::CHR_OCT_LO);
            oct_cnt = oct_cnt + 2'd1;
            if (oct_cnt >= bsd_pkg::OCT_MAX_DIGITS) begin
               rr[n] = {oct_val, 2'b00};
               n = n + 1;
               dec_mode = bsd_pkg::MODE_PLAIN;
               oct_val  = 8'h00;
               oct_cnt  = 2'd0;
            end
         end else begin
            // flush pending value, then treat the byte as plain text
            rr[n] = {oct_val, 2'b00};
            n = n + 1;
            oct_val = 8'h00;
            oct_cnt = 2'd0;
            take_plain = 1'b1;
         end
      end else begin
         take_plain = 1'b1;   // plain, and the unused mode code
      end
      if (take_plain) begin
         if (c == bsd_pkg::CHR_BSLASH) begin
            dec_mode = bsd_pkg::MODE_ESC;
         end else begin
            dec_mode = bsd_pkg::MODE_PLAIN;
            rr[n] = {c, 2'b00};
            n = n + 1;
         end
      end
      if (n > 0)
         rr[n - 1].run_last = 1'b1;
      r0 = rr[0];
      r1 = rr[1];
      return n;
   endfunction

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55)
         return 0;
      if (p < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] esc_char();
      case ($urandom_range(0, 11))
         0: return bsd_pkg::CHR_N;
         1: return bsd_pkg::CHR_T;
         2: return bsd_pkg::CHR_R;
         3: return bsd_pkg::CHR_B;
         4: return bsd_pkg::CHR_F;
         5: return bsd_pkg::CHR_BSLASH;
         6: return 8'h20;
         7: return 8'h00;
         8: return 8'($urandom_range(bsd_pkg::CHR_OCT_LO, bsd_pkg::CHR_OCT_HI));
         9: return ($urandom_range(0, 1) != 0) ? 8'h38 : 8'h2F;   // just outside octal
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_text();
      int target;
      int kind;
      // directed part
      add_text(8'hFF, 1'b1, 1, END_ONLY, NO_RES);
      add_text(8'hFF, 1'b0, 1, {8'hFF, 2'b01}, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_N, 1'b0, 1, {bsd_pkg::CTL_LF, 2'b01}, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_T, 1'b0, 1, {bsd_pkg::CTL_HT, 2'b01}, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_R, 1'b0, 1, {bsd_pkg::CTL_CR, 2'b01}, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_B, 1'b0, 1, {bsd_pkg::CTL_BS, 2'b01}, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_F, 1'b0, 1, {bsd_pkg::CTL_FF, 2'b01}, NO_RES);
      // zero byte after a backslash
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES);
      add_text(8'h00, 1'b0, USE_MODEL, NO_RES, NO_RES);
      // three digits, value truncated to a byte
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_OCT_HI, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_OCT_HI, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_OCT_HI, 1'b0, 1, {8'hFF, 2'b01}, NO_RES);
      // backslash flushes octal, then dangles at the end
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(8'h31, 1'b0, 0, NO_RES, NO_RES);
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 1, {8'h01, 2'b01}, NO_RES);
      add_text(8'hA5, 1'b1, 2, {bsd_pkg::CHR_BSLASH, 2'b00}, END_ONLY);
      // pending octal at the end
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, 0, NO_RES, NO_RES);
      add_text(8'h35, 1'b0, 0, NO_RES, NO_RES);
      add_text(8'h00, 1'b1, 2, {8'h05, 2'b00}, END_ONLY);
      // ordinary byte flushes octal, gives a second result
      add_text(bsd_pkg::CHR_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES);
      add_text(8'h34, 1'b0, USE_MODEL, NO_RES, NO_RES);
      add_text(8'h5A, 1'b0, USE_MODEL, NO_RES, NO_RES);

      target = text_q.size() + RANDOM_ITEMS;
      while (text_q.size() < target) begin
         kind = $urandom_range(0, 19);
         if (kind < 5) begin
            add_text(8'($urandom_range(0, 255)), 1'b0, USE_MODEL, NO_RES, NO_RES);
         end else if (kind < 9) begin
            add_text(bsd_pkg::CHR_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES);
            add_text(esc_char(), 1'b0, USE_MODEL, NO_RES, NO_RES);
         end else if (kind < 14) begin
            add_text(bsd_pkg::CHR_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES);
            repeat ($urandom_range(1, 3))
               add_text(8'($urandom_range(bsd_pkg::CHR_OCT_LO, bsd_pkg::CHR_OCT_HI)),
                        1'b0, USE_MODEL, NO_RES, NO_RES);
         end else if (kind < 16) begin
            add_text(8'($urandom_range(0, 255)), 1'b1, USE_MODEL, NO_RES, NO_RES);
         end else if (kind < 18) begin
            repeat ($urandom_range(1, 4))
               add_text(($urandom_range(0, 3) == 0) ? bsd_pkg::CHR_BSLASH
                                                    : 8'($urandom_range(0, 255)),
                        $urandom_range(0, 7) == 0, USE_MODEL, NO_RES, NO_RES);
         end else begin
            add_text(bsd_pkg::CHR_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES);
            add_text(8'($urandom_range(0, 255)), 1'b1, USE_MODEL, NO_RES, NO_RES);
         end
      end
   endtask

   // request side: predict on every accepted item
   always @(posedge clock) begin : req_watch
      int                  n;
      bsd_pkg::result_type p0, p1;
      text_item_type       it;
      if (!reset && req_valid) begin
         if (!req_ready)
            n_blocked++;
         else begin
            n = decode_step(req_in_byte, req_end_flag, p0, p1);
            it = text_q[n_taken];
            if (it.nexp != USE_MODEL) begin
               n  = it.nexp;
               p0 = it.r0;
               p1 = it.r1;
            end
            if (n > 0)
               decoded_q.push_back(p0);
            if (n > 1) begin
               decoded_q.push_back(p1);
               n_pairs++;
            end
            n_taken++;
         end
      end
   end

   // response side: compare against the oldest expectation
   always @(posedge clock) begin : rsp_watch
      bsd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (decoded_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result byte %02h end %0b last %0b",
                                    rsp_out_byte, rsp_end_marker, rsp_run_last));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_end_marker !== want.end_marker)
               note_mismatch($sformatf("end marker %0b, expected %0b (byte %02h)",
                                       rsp_end_marker, want.end_marker, want.out_byte));
            else if (!want.end_marker && rsp_out_byte !== want.out_byte)
               note_mismatch($sformatf("byte %02h, expected %02h",
                                       rsp_out_byte, want.out_byte));
            if (rsp_run_last !== want.run_last)
               note_mismatch($sformatf("run_last %0b, expected %0b (byte %02h end %0b)",
                                       rsp_run_last, want.run_last, want.out_byte,
                                       want.end_marker));
            if (want.end_marker)
               n_strings++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, decoded_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off to back up the queue
   initial begin : rsp_side
      int run;
      int hold;
      bit held;
      held = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (!held && n_taken >= 300) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 12);
         repeat (run) @(negedge clock);
         hold = idle_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   // sender
   initial begin : req_side
      int gap;
      build_text();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < text_q.size(); i++) begin
         // every fifth block of 50 items goes back to back
         gap = (((i / 50) % 5) == 2) ? 0 : idle_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid    <= 1'b1;
         req_in_byte  <= text_q[i].ch;
         req_end_flag <= text_q[i].endf;
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d gave two results), checked %0d results, %0d strings.",
               n_taken, n_pairs, n_results, n_strings);
      $display("Input stalled by back-pressure for %0d cycles; %0d mismatches.",
               n_blocked, n_errors);
      if (n_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
